### sv/dtfp_pkg.sv
package dtfp_pkg;

  // default configuration of the converter
  localparam int unsigned IntBitsDef       = 15;
  localparam int unsigned FracBitsDef      = 16;
  localparam int unsigned GuardBitsDef     = 16;
  localparam int unsigned MaxFracDigitsDef = 9;

  // parser phase codes
  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_INT   = 2'd2;
  localparam logic [1:0] PH_FRAC  = 2'd3;

  // character codes
  localparam logic [7:0] CH_NUL      = 8'd0;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_PLUS     = 8'd43;
  localparam logic [7:0] CH_MINUS    = 8'd45;
  localparam logic [7:0] CH_DOT      = 8'd46;
  localparam logic [8:0] DIGIT_ZERO  = 9'd48;

  // terminator handoff from parser to finish stage
  typedef struct packed {
    logic valid;
    logic negative;
    logic saturated;
  } term_t;

  // round(2^fg / 10^(pos+1)), evaluated at elaboration only
  function automatic longint unsigned recip_pow10(int unsigned fg, int unsigned pos);
    longint unsigned q;
    q = 64'd1 << (fg + 1);
    for (int unsigned i = 0; i <= pos; i++) begin
      q = q / 10;
    end
    return (q + 64'd1) >> 1;
  endfunction

  // number of bits of the result range, capped at the 32-bit word
  function automatic int unsigned range_bits(int unsigned ib, int unsigned fb);
    return (ib + fb > 31) ? 31 : ib + fb;
  endfunction

  // upper saturation limit
  function automatic longint sat_hi(int unsigned ib, int unsigned fb);
    return (64'sd1 <<< range_bits(ib, fb)) - 64'sd1;
  endfunction

  // lower saturation limit
  function automatic longint sat_lo(int unsigned ib, int unsigned fb);
    return -(64'sd1 <<< range_bits(ib, fb));
  endfunction

endpackage

### sv/dtfp_parser.sv
module dtfp_parser
  import dtfp_pkg::*;
#(
  parameter int unsigned FRAC_BITS       = FracBitsDef,
  parameter int unsigned GUARD_BITS      = GuardBitsDef,
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef,
  localparam int unsigned FAW            = FRAC_BITS + GUARD_BITS + 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            ch_i,
  input  logic                  term_ready_i,
  output term_t                 term_o,
  output logic signed [31:0]    int_acc_o,
  output logic signed [FAW-1:0] frac_acc_o
);

  localparam int unsigned RW  = FRAC_BITS + GUARD_BITS;
  localparam int unsigned FDW = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int unsigned IW  = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
  localparam int unsigned TAB = 2 ** IW;
  localparam logic signed [35:0] IntMax = 36'sd2147483647;
  localparam logic signed [35:0] IntMin = -36'sd2147483648;

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  logic [1:0]            phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic signed [31:0]    int_q, int_d;
  logic signed [FAW-1:0] frac_q, frac_d;
  logic [FDW-1:0]        fd_q, fd_d;
  logic                  sat_q, sat_d;

  logic                  is_term, go, take_ch;
  logic                  is_space, is_sign, pass_space, at_sign, at_int;
  logic signed [8:0]     dig;
  logic signed [35:0]    int_next;
  logic [RW-1:0]         recip_tab [TAB];
  logic [RW-1:0]         recip_sel;
  logic signed [FAW-1:0] frac_prod;

  // reciprocal power-of-ten table, constant
  always_comb begin
    for (int unsigned k = 0; k < TAB; k++) begin
      recip_tab[k] = (k < MAX_FRAC_DIGITS) ? RW'(recip_pow10(RW, k)) : '0;
    end
  end

  // input register handshake
  assign is_term    = (ch_q == CH_NUL);
  assign go         = in_valid_q && (!is_term || term_ready_i);
  assign in_stall_o = in_valid_q && !go;
  assign take_ch    = go && !is_term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q <= ch_i;
    end
  end

  // character classes and the phase it lands in
  assign is_space   = ((ch_q >= CH_TAB) && (ch_q <= CH_CR)) || (ch_q == CH_SPACE);
  assign is_sign    = (ch_q == CH_PLUS) || (ch_q == CH_MINUS);
  assign pass_space = (phase_q == PH_SPACE) && !is_space;
  assign at_sign    = (phase_q == PH_SIGN) || pass_space;
  assign at_int     = (phase_q == PH_INT) || (at_sign && !is_sign);
  assign dig        = $signed({1'b0, ch_q}) - $signed(DIGIT_ZERO);

  // integer part: ten times previous plus digit, clamped
  assign int_next = (36'(int_q) <<< 3) + (36'(int_q) <<< 1) + 36'(dig);

  // fraction part: digit times table entry
  assign recip_sel = recip_tab[fd_q[IW-1:0]];
  assign frac_prod = FAW'(dig) * FAW'($signed({1'b0, recip_sel}));

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fd_d    = fd_q;
    sat_d   = sat_q;
    if (go && is_term) begin
      phase_d = PH_SPACE;
      neg_d   = 1'b0;
      int_d   = '0;
      frac_d  = '0;
      fd_d    = '0;
      sat_d   = 1'b0;
    end else if (take_ch) begin
      if (at_sign && is_sign) begin
        phase_d = PH_SIGN;
        if (ch_q == CH_MINUS) begin
          neg_d = !neg_q;
        end
      end else if (at_int) begin
        if (ch_q == CH_DOT) begin
          phase_d = PH_FRAC;
        end else begin
          phase_d = PH_INT;
          if (!sat_q) begin
            if (int_next > IntMax) begin
              int_d = 32'(IntMax);
              sat_d = 1'b1;
            end else if (int_next < IntMin) begin
              int_d = 32'(IntMin);
              sat_d = 1'b1;
            end else begin
              int_d = 32'(int_next);
            end
          end
        end
      end else if (phase_q == PH_FRAC) begin
        if (fd_q < FDW'(MAX_FRAC_DIGITS)) begin
          frac_d = frac_q + frac_prod;
          fd_d   = fd_q + 1'b1;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      fd_q    <= '0;
      sat_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      fd_q    <= fd_d;
      sat_q   <= sat_d;
    end
  end

  // state as seen by the terminator
  assign term_o.valid     = in_valid_q && is_term;
  assign term_o.negative  = neg_q;
  assign term_o.saturated = sat_q;
  assign int_acc_o        = int_q;
  assign frac_acc_o       = frac_q;

endmodule

### sv/dtfp_finish.sv
module dtfp_finish
  import dtfp_pkg::*;
#(
  parameter int unsigned INT_BITS   = IntBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned GUARD_BITS = GuardBitsDef,
  localparam int unsigned FAW       = FRAC_BITS + GUARD_BITS + 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  term_t                 term_i,
  input  logic signed [31:0]    int_acc_i,
  input  logic signed [FAW-1:0] frac_acc_i,
  output logic                  term_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    value_o,
  output logic                  overflow_o
);

  localparam int unsigned TW = FRAC_BITS + 35;
  localparam longint ClipL   = ((64'sd1 <<< 31) >>> FRAC_BITS) + 64'sd64;
  localparam logic signed [32:0] ClipP = 33'(ClipL);
  localparam logic signed [32:0] ClipN = -33'(ClipL);
  localparam logic signed [TW-1:0] HiT = TW'(sat_hi(INT_BITS, FRAC_BITS));
  localparam logic signed [TW-1:0] LoT = TW'(sat_lo(INT_BITS, FRAC_BITS));

  logic                  snap_valid_q;
  logic                  snap_neg_q, snap_sat_q;
  logic signed [31:0]    snap_int_q;
  logic signed [FAW-1:0] snap_frac_q;
  logic                  out_valid_q;
  logic signed [31:0]    value_q, value_d;
  logic                  ovf_q, ovf_d;

  logic                  out_ready, snap_adv;
  logic signed [TW-1:0]  fr_ext, ip_ext, t_sum, t_sgn;
  logic signed [32:0]    ip_wide, ip_clip;

  // flow control between snapshot and output register
  assign out_ready    = !out_valid_q || !out_stall_i;
  assign snap_adv     = !snap_valid_q || out_ready;
  assign term_ready_o = snap_adv;

  // snapshot of the parser state at the terminator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_adv) begin
      snap_valid_q <= term_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv && term_i.valid) begin
      snap_neg_q  <= term_i.negative;
      snap_sat_q  <= term_i.saturated;
      snap_int_q  <= int_acc_i;
      snap_frac_q <= frac_acc_i;
    end
  end

  // round fraction to nearest, ties upward
  if (GUARD_BITS > 0) begin : g_round
    logic signed [FAW:0] rnd_sum;
    assign rnd_sum = (FAW + 1)'(snap_frac_q) + (FAW + 1)'(64'sd1 <<< (GUARD_BITS - 1));
    assign fr_ext  = TW'(rnd_sum >>> GUARD_BITS);
  end else begin : g_noround
    assign fr_ext = TW'(snap_frac_q);
  end

  // clamp integer part, combine, apply sign and saturate
  assign ip_wide = 33'(snap_int_q);
  assign ip_clip = (ip_wide > ClipP) ? ClipP : ((ip_wide < ClipN) ? ClipN : ip_wide);
  assign ip_ext  = TW'(ip_clip) <<< FRAC_BITS;
  assign t_sum   = ip_ext + fr_ext;
  assign t_sgn   = snap_neg_q ? -t_sum : t_sum;

  always_comb begin
    value_d = t_sgn[31:0];
    ovf_d   = snap_sat_q;
    if (t_sgn > HiT) begin
      value_d = HiT[31:0];
      ovf_d   = 1'b1;
    end else if (t_sgn < LoT) begin
      value_d = LoT[31:0];
      ovf_d   = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && snap_valid_q) begin
      value_q <= value_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign overflow_o  = ovf_q;

endmodule

### sv/decimal_text_to_fixed_point.sv
// channel | signals                        | transaction
// --------+--------------------------------+------------------------------------
// in      | in_valid_i, in_stall_o, ch_i   | one character code, 0 ends a number
// out     | out_valid_o, out_stall_i,      | one fixed-point result per number
//         | value_o, overflow_o            |
//
// one character per cycle while in_stall_o is low; the parser recurrence (integer
// times ten plus digit, fraction digit times table entry) is combinational.
// a result passes from its terminating zero through the input register, the
// terminator snapshot and the result register.
// reset is asynchronous and clears the handshake valids and the parser state.
// out_stall_i holds the result; a terminator then waits in the input register only
// while snapshot and result are both full, other characters keep flowing.
module decimal_text_to_fixed_point
  import dtfp_pkg::*;
#(
  parameter int unsigned INT_BITS        = IntBitsDef,
  parameter int unsigned FRAC_BITS       = FracBitsDef,
  parameter int unsigned GUARD_BITS      = GuardBitsDef,
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               overflow_o
);

  localparam int unsigned FAW = FRAC_BITS + GUARD_BITS + 6;

  term_t                 term;
  logic                  term_ready;
  logic signed [31:0]    int_acc;
  logic signed [FAW-1:0] frac_acc;

  // character parser with input register
  dtfp_parser #(
    .FRAC_BITS       (FRAC_BITS),
    .GUARD_BITS      (GUARD_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .term_ready_i (term_ready),
    .term_o       (term),
    .int_acc_o    (int_acc),
    .frac_acc_o   (frac_acc)
  );

  // rounding, sign and saturation with result register
  dtfp_finish #(
    .INT_BITS   (INT_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .GUARD_BITS (GUARD_BITS)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (term),
    .int_acc_i    (int_acc),
    .frac_acc_i   (frac_acc),
    .term_ready_o (term_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .overflow_o   (overflow_o)
  );

`ifndef SYNTHESIS
  // result always lies in the saturation range
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (64'(value_o) <= sat_hi(INT_BITS, FRAC_BITS) &&
                     64'(value_o) >= sat_lo(INT_BITS, FRAC_BITS)))
    else $error("result outside saturation range");

  // an overflowing result sits on one of the limits
  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (64'(value_o) == sat_hi(INT_BITS, FRAC_BITS) ||
       64'(value_o) == sat_lo(INT_BITS, FRAC_BITS)))
    else $error("overflow flagged on a value off the limits");

  // input side only stalls under output backpressure
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");
`endif

endmodule
